// ===== src/glbp_pkg.sv =====
`timescale 1ns / 1ps
// Package for the geometry blob linestring parser: phase enum, result record,
// result kinds, error codes and header constants. No dependencies.
package glbp_pkg;

  typedef enum logic [3:0] {
    PH_IDLE, PH_MAGIC1, PH_VERSION, PH_FLAGS, PH_SRS, PH_ENVELOPE,
    PH_ORDER, PH_TYPE, PH_COUNT, PH_POINTS, PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    KIND_POINT = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ERR_NONE      = 4'd0,
    ERR_SHORT     = 4'd1,
    ERR_MAGIC     = 4'd2,
    ERR_VERSION   = 4'd3,
    ERR_ENV_TYPE  = 4'd4,
    ERR_ENV_OVER  = 4'd5,
    ERR_ORDER     = 4'd6,
    ERR_TRUNC_TYP = 4'd7,
    ERR_NOT_LINE  = 4'd8,
    ERR_TRUNC_PTS = 4'd9
  } err_t;

  // One result item as handed from the parser to the output queue
  typedef struct packed {
    kind_t       kind;
    err_t        code;
    logic [63:0] x_bits;
    logic [63:0] y_bits;
    logic [63:0] z_bits;
    logic        has_z;
    logic        last;
  } result_t;

  localparam logic [7:0]  MAGIC_G      = 8'h47;
  localparam logic [7:0]  MAGIC_P      = 8'h50;
  localparam logic [7:0]  ORDER_LE     = 8'h01;
  localparam logic [27:0] TYPE_LINE    = 28'd2;
  localparam int          MIN_LENGTH   = 8;
  localparam int          HEADER_BYTES = 8;
  localparam int          OUT_TDATA_W  = 200;

  // Envelope byte count by indicator 0..4
  function automatic logic [6:0] env_size(input logic [2:0] ind);
    logic [6:0] s;
    unique case (ind)
      3'd0:    s = 7'd0;
      3'd1:    s = 7'd32;
      3'd2:    s = 7'd48;
      3'd3:    s = 7'd48;
      default: s = 7'd64;
    endcase
    return s;
  endfunction

endpackage

// ===== src/geometry_blob_linestring_parser.sv =====
`timescale 1ns / 1ps
// Top level of the geometry blob linestring parser: parser front plus
// result queue. Uses glbp_pkg, glbp_front and glbp_queue.
//
// Takes one blob byte per cycle and gives at most one result per byte, so
// the sustained rate is one item per cycle; a result is registered in the
// queue with the byte that completes it. The input is held off only
// while the two-entry result queue is full, i.e. when the output side
// stalls. A blob start byte always restarts parsing; bytes after the last
// point, after an error or while idle are taken and dropped.
module geometry_blob_linestring_parser #(
  parameter int LENGTH_BITS = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // byte_value[7:0], blob_length[31:8]
  input  logic         in_tuser,   // blob_start
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [199:0] out_tdata,  // error_code[3:0], x_bits[67:4], y_bits[131:68],
                                   // z_bits[195:132], point_has_z[196], zero pad
  output logic [1:0]   out_tuser,  // result_kind
  output logic         out_tlast   // last_of_blob
);

  logic              accept;
  logic              res_valid;
  glbp_pkg::result_t res;
  glbp_pkg::result_t q_data;

  assign accept = in_tvalid && in_tready;

  glbp_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .byte_value  (in_tdata[7:0]),
    .blob_start  (in_tuser),
    .blob_length (in_tdata[31:8]),
    .res_valid   (res_valid),
    .res         (res)
  );

  glbp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .has_space (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (q_data)
  );

  // Pack the result onto the stream ports
  assign out_tdata = {3'b000, q_data.has_z, q_data.z_bits, q_data.y_bits,
                      q_data.x_bits, q_data.code};
  assign out_tuser = q_data.kind;
  assign out_tlast = q_data.last;

endmodule

// ===== src/glbp_front.sv =====
`timescale 1ns / 1ps
// Front part: accepts blob bytes, walks the header/WKB phases, assembles
// points and produces at most one result per byte. Uses glbp_pkg.
module glbp_front #(
  parameter int LENGTH_BITS = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          byte_value,
  input  logic                blob_start,
  input  logic [23:0]         blob_length,
  output logic                res_valid,
  output glbp_pkg::result_t   res
);

  localparam int EW = LENGTH_BITS + 1;
  localparam int CW = 40;

  glbp_pkg::phase_t phase_r, phase_nxt;
  logic [LENGTH_BITS-1:0] off_r, off_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic [6:0]  env_r, env_nxt;
  logic [31:0] word_r, word_nxt;
  logic [31:0] pts_r, pts_nxt;
  logic        z_r, z_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic [7:0]  coord_r [24];
  logic [7:0]  coord_nxt [24];

  logic [LENGTH_BITS-1:0] len_in;
  logic [2:0]  env_ind;
  logic [4:0]  stride;
  logic [4:0]  idx;
  logic [CW-1:0] need;
  logic        ord_short;
  logic        env_over;

  assign len_in    = LENGTH_BITS'(blob_length);
  assign env_ind   = byte_value[3:1];
  assign stride    = z_r ? 5'd24 : 5'd16;
  assign idx       = (pos_r >= stride) ? stride - 5'd1 : pos_r;
  assign ord_short = ({1'b0, off_r} + EW'(5)) > {1'b0, len_r};
  assign env_over  = (EW'(glbp_pkg::HEADER_BYTES) + EW'(glbp_pkg::env_size(env_ind)))
                     >= {1'b0, len_r};
  // Exact byte demand of the point data: offset + 1 + count * stride
  assign need = CW'(off_r) + CW'(1) + (CW'(word_nxt) << 4)
              + (z_r ? (CW'(word_nxt) << 3) : CW'(0));

  // Word assembly: current byte lands in lane pos
  always_comb begin
    word_nxt = word_r;
    unique case (pos_r[1:0])
      2'd0: word_nxt[7:0]   = byte_value;
      2'd1: word_nxt[15:8]  = byte_value;
      2'd2: word_nxt[23:16] = byte_value;
      default: word_nxt[31:24] = byte_value;
    endcase
  end

  // Phase sequencing and result generation
  always_comb begin
    logic adv;
    logic fail;
    glbp_pkg::err_t fcode;
    adv       = 1'b0;
    fail      = 1'b0;
    fcode     = glbp_pkg::ERR_NONE;
    phase_nxt = phase_r;
    off_nxt   = off_r;
    len_nxt   = len_r;
    env_nxt   = env_r;
    pts_nxt   = pts_r;
    z_nxt     = z_r;
    pos_nxt   = pos_r;
    coord_nxt = coord_r;
    res_valid = 1'b0;
    res       = '0;
    res.kind  = glbp_pkg::KIND_POINT;
    res.code  = glbp_pkg::ERR_NONE;

    if (accept && blob_start) begin
      off_nxt = '0;
      env_nxt = '0;
      pts_nxt = '0;
      z_nxt   = 1'b0;
      pos_nxt = '0;
      len_nxt = len_in;
      if (len_in < LENGTH_BITS'(glbp_pkg::MIN_LENGTH)) begin
        fail = 1'b1; fcode = glbp_pkg::ERR_SHORT;
      end else if (byte_value != glbp_pkg::MAGIC_G) begin
        fail = 1'b1; fcode = glbp_pkg::ERR_MAGIC;
      end else begin
        phase_nxt = glbp_pkg::PH_MAGIC1;
        off_nxt   = LENGTH_BITS'(1);
      end
    end else if (accept) begin
      unique case (phase_r)
        glbp_pkg::PH_MAGIC1: begin
          if (byte_value != glbp_pkg::MAGIC_P) begin
            fail = 1'b1; fcode = glbp_pkg::ERR_MAGIC;
          end else begin
            phase_nxt = glbp_pkg::PH_VERSION; adv = 1'b1;
          end
        end
        glbp_pkg::PH_VERSION: begin
          if (byte_value != 8'd0) begin
            fail = 1'b1; fcode = glbp_pkg::ERR_VERSION;
          end else begin
            phase_nxt = glbp_pkg::PH_FLAGS; adv = 1'b1;
          end
        end
        glbp_pkg::PH_FLAGS: begin
          if (env_ind > 3'd4) begin
            fail = 1'b1; fcode = glbp_pkg::ERR_ENV_TYPE;
          end else if (env_over) begin
            fail = 1'b1; fcode = glbp_pkg::ERR_ENV_OVER;
          end else begin
            env_nxt   = glbp_pkg::env_size(env_ind);
            pos_nxt   = '0;
            phase_nxt = glbp_pkg::PH_SRS;
            adv       = 1'b1;
          end
        end
        glbp_pkg::PH_SRS: begin
          adv = 1'b1;
          if (pos_r >= 5'd3) begin
            pos_nxt   = '0;
            phase_nxt = (env_r != 7'd0) ? glbp_pkg::PH_ENVELOPE : glbp_pkg::PH_ORDER;
          end else begin
            pos_nxt = pos_r + 5'd1;
          end
        end
        glbp_pkg::PH_ENVELOPE: begin
          adv = 1'b1;
          env_nxt = (env_r != 7'd0) ? env_r - 7'd1 : env_r;
          if (env_nxt == 7'd0) phase_nxt = glbp_pkg::PH_ORDER;
        end
        glbp_pkg::PH_ORDER: begin
          if (byte_value != glbp_pkg::ORDER_LE) begin
            fail = 1'b1; fcode = glbp_pkg::ERR_ORDER;
          end else if (ord_short) begin
            fail = 1'b1; fcode = glbp_pkg::ERR_TRUNC_TYP;
          end else begin
            pos_nxt = '0; phase_nxt = glbp_pkg::PH_TYPE; adv = 1'b1;
          end
        end
        glbp_pkg::PH_TYPE: begin
          if (pos_r >= 5'd3) begin
            z_nxt = word_nxt[31];
            if (word_nxt[27:0] != glbp_pkg::TYPE_LINE) begin
              fail = 1'b1; fcode = glbp_pkg::ERR_NOT_LINE;
            end else if (ord_short) begin
              fail = 1'b1; fcode = glbp_pkg::ERR_TRUNC_PTS;
            end else begin
              pos_nxt = '0; phase_nxt = glbp_pkg::PH_COUNT; adv = 1'b1;
            end
          end else begin
            pos_nxt = pos_r + 5'd1; adv = 1'b1;
          end
        end
        glbp_pkg::PH_COUNT: begin
          if (pos_r >= 5'd3) begin
            pos_nxt = '0;
            pts_nxt = word_nxt;
            if (need > CW'(len_r)) begin
              fail = 1'b1; fcode = glbp_pkg::ERR_TRUNC_PTS;
            end else if (word_nxt == 32'd0) begin
              phase_nxt = glbp_pkg::PH_DONE;
              res_valid = 1'b1;
              res.kind  = glbp_pkg::KIND_EMPTY;
              res.has_z = z_r;
              res.last  = 1'b1;
              adv       = 1'b1;
            end else begin
              phase_nxt = glbp_pkg::PH_POINTS; adv = 1'b1;
            end
          end else begin
            pos_nxt = pos_r + 5'd1; adv = 1'b1;
          end
        end
        glbp_pkg::PH_POINTS: begin
          adv = 1'b1;
          // Each byte fills its own lane; a point writes each of its stride lanes once
          for (int i = 0; i < 24; i++) begin
            if (idx == 5'(i)) coord_nxt[i] = byte_value;
          end
          pos_nxt = idx + 5'd1;
          if (pos_nxt >= stride) begin
            pos_nxt   = '0;
            pts_nxt   = pts_r - 32'd1;
            res_valid = 1'b1;
            res.kind  = glbp_pkg::KIND_POINT;
            res.x_bits = {coord_nxt[7],  coord_nxt[6],  coord_nxt[5],  coord_nxt[4],
                          coord_nxt[3],  coord_nxt[2],  coord_nxt[1],  coord_nxt[0]};
            res.y_bits = {coord_nxt[15], coord_nxt[14], coord_nxt[13], coord_nxt[12],
                          coord_nxt[11], coord_nxt[10], coord_nxt[9],  coord_nxt[8]};
            res.z_bits = z_r ? {coord_nxt[23], coord_nxt[22], coord_nxt[21],
                                coord_nxt[20], coord_nxt[19], coord_nxt[18],
                                coord_nxt[17], coord_nxt[16]} : 64'd0;
            res.has_z  = z_r;
            res.last   = (pts_r == 32'd1);
            if (pts_r == 32'd1) phase_nxt = glbp_pkg::PH_DONE;
          end
        end
        default: begin
          // idle or finished: byte ignored
        end
      endcase
    end

    if (fail) begin
      phase_nxt = glbp_pkg::PH_DONE;
      res_valid = 1'b1;
      res       = '0;
      res.kind  = glbp_pkg::KIND_ERROR;
      res.code  = fcode;
      res.last  = 1'b1;
    end
    if (adv) off_nxt = off_r + LENGTH_BITS'(1);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= glbp_pkg::PH_IDLE;
      off_r   <= '0;
      len_r   <= '0;
      env_r   <= '0;
      pts_r   <= '0;
      z_r     <= 1'b0;
      pos_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      off_r   <= off_nxt;
      len_r   <= len_nxt;
      env_r   <= env_nxt;
      pts_r   <= pts_nxt;
      z_r     <= z_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // Assembly registers; word cleared at each field boundary
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
    end else if (accept && (phase_r == glbp_pkg::PH_TYPE ||
                            phase_r == glbp_pkg::PH_COUNT) && !blob_start) begin
      word_r <= (pos_r >= 5'd3) ? 32'd0 : word_nxt;
    end else if (accept) begin
      word_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    coord_r <= coord_nxt;
  end

endmodule

// ===== src/glbp_queue.sv =====
`timescale 1ns / 1ps
// Back part: two-entry result queue that holds finished results until the
// output side takes them. Uses glbp_pkg.
module glbp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  glbp_pkg::result_t push_data,
  output logic              has_space,
  output logic              out_valid,
  input  logic              out_ready,
  output glbp_pkg::result_t out_data
);

  glbp_pkg::result_t mem [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != 2'd0);
  assign has_space = (count_r != 2'd2);
  assign out_data  = mem[rd_ptr_r];

  // Occupancy
  always_comb begin
    count_nxt = count_r;
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

endmodule

// ===== src/glbp_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the geometry blob linestring parser, bound to the
// top level. Uses glbp_pkg.
module glbp_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [199:0] out_tdata,
  input logic [1:0]   out_tuser,
  input logic         out_tlast
);

  // Stalled result stays valid
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // Errors and empty linestrings always end the blob
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == glbp_pkg::KIND_ERROR || out_tuser == glbp_pkg::KIND_EMPTY)
    |-> out_tlast)
    else $error("terminal result without last");

  // Non-error results carry no error code; errors carry one
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tuser == glbp_pkg::KIND_ERROR) == (out_tdata[3:0] != 4'd0)))
    else $error("error code does not match kind");

  // Error and empty results have zero coordinates
  a_zero_coord: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != glbp_pkg::KIND_POINT |-> out_tdata[195:4] == '0)
    else $error("coordinates on non-point result");

  // Points without Z report zero z
  a_no_z: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[196] |-> out_tdata[195:132] == 64'd0)
    else $error("z bits set without Z");

endmodule

bind geometry_blob_linestring_parser glbp_checker u_glbp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
